FILE: sv/idw_pkg.sv
// ----------------------------------------------------------------------------
// idw_pkg
// Shared types, register indexes and constants of the inverse distance
// weighting interpolator.
// ----------------------------------------------------------------------------
package idw_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  localparam logic [1:0] REG_POWER   = 2'd0;
  localparam logic [1:0] REG_MISSING = 2'd1;
  localparam logic [1:0] REG_DLIMIT  = 2'd2;

  localparam logic        [11:0] POWER_RST   = 12'd256;
  localparam logic signed [31:0] MISSING_RST = -32'sd655294464;
  localparam logic signed [31:0] DLIMIT_RST  = 32'sh8000_0000;

  // weight is at most 1.0 in Q.21, weight times sample is a 55 bit product
  localparam int W_BITS  = 22;
  localparam int WV_BITS = 55;
  localparam int E_BITS  = 28;

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  typedef struct packed {
    logic        [11:0] power;
    logic signed [31:0] missing;
    logic signed [31:0] dlimit;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic signed [31:0] uncertainty;
    logic               undef;
  } res_t;

  // 2^(2^-j) in Q.30 for j = 1..16, each the floor square root of the one before
  function automatic logic [15:0][30:0] root_table();
    logic [15:0][30:0] tab;
    logic [63:0] root;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    int j;
    int s;
    tab  = '0;
    root = 64'd1 << 31;
    for (j = 15; j >= 0; j--) begin
      v     = root << 30;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (s = 0; s < 32; s++) begin
        if (v >= res + bit_v) begin
          v   = v - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      root   = res;
      tab[j] = root[30:0];
    end
    return tab;
  endfunction

  localparam logic [15:0][30:0] ROOT_TAB = root_table();

endpackage

FILE: sv/idw_fifo.sv
// ----------------------------------------------------------------------------
// idw_fifo
// Small first-word-fall-through queue used between front and back and in
// front of the result ports.
// ----------------------------------------------------------------------------
module idw_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: sv/idw_front.sv
// ----------------------------------------------------------------------------
// idw_front
// Input side: takes items, drops unknown commands and queues the rest for
// the back end.
// ----------------------------------------------------------------------------
module idw_front (
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic signed [31:0] x_pos,
  input  logic signed [31:0] y_pos,
  input  logic signed [31:0] sample,
  input  logic               q_full,
  output logic               q_push,
  output idw_pkg::item_t     q_item
);
  import idw_pkg::*;

  logic known;

  always_comb begin
    unique case (command)
      CMD_CLEAR, CMD_LOAD, CMD_QUERY: known = 1'b1;
      default:                        known = 1'b0;
    endcase
  end

  assign full          = q_full;
  assign q_push        = push && !q_full && known;
  assign q_item.cmd    = cmd_e'(command);
  assign q_item.x      = x_pos;
  assign q_item.y      = y_pos;
  assign q_item.sample = sample;

endmodule

FILE: sv/idw_div.sv
// ----------------------------------------------------------------------------
// idw_div
// Restoring divider: signed numerator over positive denominator, one
// quotient bit per cycle, 32 bit quotient truncated toward zero.
// ----------------------------------------------------------------------------
module idw_div #(
  parameter int NW = 61,
  parameter int DW = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic                 done,
  output logic signed [31:0]   quo
);
  logic          busy;
  logic [4:0]    cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dq;
  logic [31:0]   qsh;
  logic          neg;
  logic [NW-1:0] mag;
  logic [DW:0]   r2;
  logic          ge;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign r2  = {rem, qsh[31]};
  assign ge  = (r2 >= {1'b0, dq});
  assign quo = neg ? 32'(-qsh) : qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        rem  <= DW'(mag >> 32);
        qsh  <= mag[31:0];
        neg  <= num[NW-1];
        dq   <= den;
      end else if (busy) begin
        rem <= ge ? DW'(r2 - {1'b0, dq}) : DW'(r2);
        qsh <= {qsh[30:0], ge};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/idw_engine.sv
// ----------------------------------------------------------------------------
// idw_engine
// Back end: station store, two passes over the stations (log distance
// exponent, then weight and accumulate) and the final division.
// ----------------------------------------------------------------------------
module idw_engine #(
  parameter int MAX_STATIONS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  idw_pkg::cfg_t  cfg,
  input  logic           cmd_empty,
  input  idw_pkg::item_t cmd_item,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output idw_pkg::res_t  res_item
);
  import idw_pkg::*;

  localparam int IW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int CW = $clog2(MAX_STATIONS + 1);
  localparam int DW = W_BITS + IW;
  localparam int NW = WV_BITS + IW;

  typedef enum logic [4:0] {
    S_IDLE, S_P1_RD, S_P1_DIFF, S_P1_SQ, S_P1_SUM, S_P1_NORM, S_P1_LOG,
    S_P1_MUL, S_P1_E, S_P2_RD, S_P2_G, S_P2_POW, S_P2_W, S_P2_MAC,
    S_P2_ACC, S_DSTART, S_DWAIT, S_FIN
  } state_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] v;
  } st_t;

  state_t state;

  st_t                     st_mem [MAX_STATIONS];
  logic signed [E_BITS-1:0] e_mem [MAX_STATIONS];
  st_t                     st_q;
  logic signed [E_BITS-1:0] e_q;

  logic [CW-1:0]            count;
  logic [IW-1:0]            idx;
  logic signed [31:0]       xc;
  logic signed [31:0]       yc;
  logic                     undef;
  logic [31:0]              ax;
  logic [31:0]              ay;
  logic [63:0]              sqx;
  logic [63:0]              sqy;
  logic [64:0]              norm;
  logic [6:0]               lz;
  logic [2:0]               step;
  logic [31:0]              m;
  logic [15:0]              frac;
  logic [3:0]               j;
  logic signed [36:0]       pe;
  logic signed [E_BITS-1:0] emax;
  logic [11:0]              k;
  logic [15:0]              t;
  logic [30:0]              acc;
  logic [W_BITS-1:0]        w;
  logic signed [WV_BITS-1:0] wv;
  logic signed [NW-1:0]     num;
  logic [DW-1:0]            den;
  logic signed [31:0]       quo_q;

  logic                     ld_en;
  logic                     last;
  logic signed [32:0]       dx;
  logic signed [32:0]       dy;
  logic [64:0]              d2;
  logic [6:0]               sh;
  logic                     top_zero;
  logic [63:0]              msq;
  logic [32:0]              mv;
  logic signed [7:0]        lexp;
  logic signed [23:0]       lval;
  logic signed [12:0]       pw_s;
  logic signed [36:0]       pb;
  logic signed [36:0]       pq;
  logic signed [E_BITS-1:0] e_val;
  logic signed [E_BITS-1:0] g;
  logic [61:0]              aprod;
  logic [12:0]              wsh;
  logic signed [W_BITS:0]   w_s;
  logic                     dv_start;
  logic                     dv_done;
  logic signed [31:0]       dv_quo;
  logic signed [31:0]       est_raw;

  assign cmd_pop  = (state == S_IDLE) && !cmd_empty;
  assign ld_en    = cmd_pop && (cmd_item.cmd == CMD_LOAD) && (count < CW'(MAX_STATIONS));
  assign last     = (CW'(idx) + CW'(1) == count);
  assign dv_start = (state == S_DSTART);
  assign res_push = (state == S_FIN) && !res_full;

  assign dx       = {st_q.x[31], st_q.x} - {xc[31], xc};
  assign dy       = {st_q.y[31], st_q.y} - {yc[31], yc};
  assign d2       = {1'b0, sqx} + {1'b0, sqy};
  assign sh       = 7'd64 >> step;
  assign top_zero = ((norm >> (7'd65 - sh)) == '0);
  assign msq      = m * m;
  assign mv       = msq[63:31];
  assign lexp     = 8'sd48 - $signed({1'b0, lz});
  assign lval     = {lexp, frac};
  assign pw_s     = $signed({1'b0, cfg.power});
  // truncate toward zero on the divide by 512
  assign pb       = pe + (pe[36] ? 37'sd511 : 37'sd0);
  assign pq       = pb >>> 9;
  assign e_val    = E_BITS'(-pq);
  assign g        = emax - e_q;
  assign aprod    = acc * ROOT_TAB[j];
  assign wsh      = {1'b0, k} + 13'd9;
  assign w_s      = $signed({1'b0, w});

  assign est_raw               = undef ? cfg.missing : quo_q;
  assign res_item.estimate     = (est_raw < cfg.dlimit) ? cfg.dlimit : est_raw;
  assign res_item.uncertainty  = undef ? cfg.missing : 32'sd0;
  assign res_item.undef        = undef;

  always_ff @(posedge clk) begin
    if (ld_en) begin
      st_mem[count[IW-1:0]] <= {cmd_item.x, cmd_item.y, cmd_item.sample};
    end
    st_q <= st_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_P1_E) begin
      e_mem[idx] <= e_val;
    end
    e_q <= e_mem[idx];
  end

  idw_div #(.NW(NW), .DW(DW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(dv_start),
    .num  (num),
    .den  (den),
    .done (dv_done),
    .quo  (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
      undef <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            unique case (cmd_item.cmd)
              CMD_CLEAR: count <= '0;
              CMD_LOAD: begin
                if (ld_en) begin
                  count <= count + CW'(1);
                end
              end
              CMD_QUERY: begin
                xc    <= cmd_item.x;
                yc    <= cmd_item.y;
                idx   <= '0;
                undef <= (count == '0);
                state <= (count == '0) ? S_FIN : S_P1_RD;
              end
              default: ;
            endcase
          end
        end
        S_P1_RD: state <= S_P1_DIFF;
        S_P1_DIFF: begin
          ax    <= dx[32] ? 32'(-dx) : dx[31:0];
          ay    <= dy[32] ? 32'(-dy) : dy[31:0];
          state <= S_P1_SQ;
        end
        S_P1_SQ: begin
          sqx   <= ax * ax;
          sqy   <= ay * ay;
          state <= S_P1_SUM;
        end
        S_P1_SUM: begin
          norm <= d2;
          lz   <= '0;
          step <= '0;
          frac <= '0;
          if (cfg.power == '0) begin
            pe    <= '0;
            state <= S_P1_E;
          end else if (d2 == '0) begin
            undef <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_P1_NORM;
          end
        end
        S_P1_NORM: begin
          // binary search for the leading one: 64, 32, ... 1
          if (top_zero) begin
            norm <= norm << sh;
            lz   <= lz + sh;
          end
          step <= step + 3'd1;
          if (step == 3'd6) begin
            state <= S_P1_LOG;
          end
        end
        S_P1_LOG: begin
          if (step == 3'd7) begin
            m    <= norm[64:33];
            j    <= 4'd15;
            step <= '0;
          end else begin
            if (mv[32]) begin
              frac[j] <= 1'b1;
              m       <= mv[32:1];
            end else begin
              m       <= mv[31:0];
            end
            j <= j - 4'd1;
            if (j == 4'd0) begin
              state <= S_P1_MUL;
            end
          end
        end
        S_P1_MUL: begin
          pe    <= pw_s * lval;
          state <= S_P1_E;
        end
        S_P1_E: begin
          if (idx == '0 || e_val > emax) begin
            emax <= e_val;
          end
          if (last) begin
            idx   <= '0;
            num   <= '0;
            den   <= '0;
            state <= S_P2_RD;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_P1_RD;
          end
        end
        S_P2_RD: state <= S_P2_G;
        S_P2_G: begin
          // 2^-g = 2^-k * 2^((65536-r)/65536) when the fraction r is nonzero
          k     <= 12'(g >>> 16) + {11'd0, (g[15:0] != 16'd0)};
          t     <= 16'(~g[15:0] + 16'd1);
          acc   <= 31'd1 << 30;
          j     <= 4'd15;
          state <= S_P2_POW;
        end
        S_P2_POW: begin
          if (t[j]) begin
            acc <= aprod[60:30];
          end
          j <= j - 4'd1;
          if (j == 4'd0) begin
            state <= S_P2_W;
          end
        end
        S_P2_W: begin
          w     <= (wsh >= 13'd31) ? '0 : W_BITS'(acc >> wsh);
          state <= S_P2_MAC;
        end
        S_P2_MAC: begin
          wv    <= w_s * st_q.v;
          state <= S_P2_ACC;
        end
        S_P2_ACC: begin
          num <= num + NW'(wv);
          den <= den + DW'(w);
          if (last) begin
            state <= S_DSTART;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_P2_RD;
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (dv_done) begin
            quo_q <= dv_quo;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/inverse_distance_weighting.sv
// ----------------------------------------------------------------------------
// inverse_distance_weighting
// Inverse distance weighted interpolation over a store of stations.
//
// Input channel (push/full): command, x_pos, y_pos, sample. Clear and load
// produce no result; an unknown command is dropped. A query produces one
// result on the output channel (empty/pop): estimate, uncertainty and
// undefined_flag, oldest first, held until popped.
// Items go through a 4 deep queue to the back end, which works one item at
// a time. A query takes the item, runs the log distance pass over every
// station (shorter when power is zero), the weight pass and the final
// divide, and hands over the result; the passes use the shared square, log,
// root-product and divide loops.
// Results wait in a 2 deep queue; when it fills the back end holds its
// finished result and the input queue fills behind it.
// Reset clears the station count, both queues and the registers to their
// defaults; the store contents need no reset. Write cfg_* only while idle.
// ----------------------------------------------------------------------------
module inverse_distance_weighting #(
  parameter int MAX_STATIONS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic signed [31:0] x_pos,
  input  logic signed [31:0] y_pos,
  input  logic signed [31:0] sample,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] estimate,
  output logic signed [31:0] uncertainty,
  output logic               undefined_flag,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import idw_pkg::*;

  cfg_t  cfg;
  item_t fr_item;
  item_t cmd_item;
  res_t  res_item;
  res_t  res_out;
  logic  fr_push;
  logic  cmd_full;
  logic  cmd_empty;
  logic  cmd_pop;
  logic  res_push;
  logic  res_full;
  logic [$bits(item_t)-1:0] cmd_dout;
  logic [$bits(res_t)-1:0]  res_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power   <= POWER_RST;
      cfg.missing <= MISSING_RST;
      cfg.dlimit  <= DLIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POWER:   cfg.power   <= cfg_data[11:0];
        REG_MISSING: cfg.missing <= $signed(cfg_data);
        REG_DLIMIT:  cfg.dlimit  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  idw_front u_front (
    .push   (push),
    .full   (full),
    .command(command),
    .x_pos  (x_pos),
    .y_pos  (y_pos),
    .sample (sample),
    .q_full (cmd_full),
    .q_push (fr_push),
    .q_item (fr_item)
  );

  idw_fifo #(.W($bits(item_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (fr_push),
    .din  (fr_item),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_dout),
    .empty(cmd_empty)
  );

  assign cmd_item = item_t'(cmd_dout);

  idw_engine #(.MAX_STATIONS(MAX_STATIONS)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_empty(cmd_empty),
    .cmd_item (cmd_item),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  idw_fifo #(.W($bits(res_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_item),
    .full (res_full),
    .pop  (pop),
    .dout (res_dout),
    .empty(empty)
  );

  assign res_out        = res_t'(res_dout);
  assign estimate       = res_out.estimate;
  assign uncertainty    = res_out.uncertainty;
  assign undefined_flag = res_out.undef;

  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fr_push |-> !cmd_full)
    else $error("command queue written while full");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_undef_unc: assert property (@(posedge clk) disable iff (rst)
    (!empty && undefined_flag) |-> (uncertainty == cfg.missing))
    else $error("undefined result without missing uncertainty");

  a_def_unc: assert property (@(posedge clk) disable iff (rst)
    (!empty && !undefined_flag) |-> (uncertainty == 32'sd0))
    else $error("defined result with nonzero uncertainty");

endmodule
